// ----- hw/rtl/brs_pkg.sv -----
// Shared types, constants and codes of the binned running statistics block.
// Depends on nothing; all other files but brs_div refer to it by scoped names.
package brs_pkg;

  localparam int NUM_BINS    = 256;
  localparam int NUM_PROPS   = 4;
  localparam int BIN_W       = $clog2(NUM_BINS);
  localparam int NUM_W       = $clog2(NUM_BINS + 1);
  localparam int STORE_DEPTH = NUM_BINS * NUM_PROPS;
  localparam int SADDR_W     = $clog2(STORE_DEPTH);

  // Configuration register indexes.
  localparam logic [1:0] CFG_X_MINIMUM      = 2'd0;
  localparam logic [1:0] CFG_X_MAXIMUM      = 2'd1;
  localparam logic [1:0] CFG_BIN_COUNT      = 2'd2;
  localparam logic [1:0] CFG_PROPERTY_TYPES = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_OUT_OF_RANGE = 3'd1;
  localparam logic [2:0] ST_ZERO_WEIGHT  = 3'd2;
  localparam logic [2:0] ST_NO_PROPERTY  = 3'd3;
  localparam logic [2:0] ST_WRONG_TYPE   = 3'd4;

  // Property type codes.
  localparam logic [2:0] PT_NONE     = 3'd0;
  localparam logic [2:0] PT_COUNT    = 3'd1;
  localparam logic [2:0] PT_SUM      = 3'd2;
  localparam logic [2:0] PT_MEAN     = 3'd3;
  localparam logic [2:0] PT_MEAN_DEV = 3'd4;
  localparam logic [2:0] PT_VALUE    = 3'd5;

  typedef enum logic [1:0] {
    OP_LOAD_EDGE,
    OP_INC_COUNT,
    OP_ADD_VALUE,
    OP_READ_BIN
  } op_e;

  typedef struct packed {
    op_e                operation;
    logic [1:0]         property_req;
    logic [7:0]         bin_index;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic [31:0]        increment;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         bin;
    logic [47:0]        total_count;
    logic signed [63:0] mean_or_sum;
    logic signed [63:0] squared_deviation;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_EARLY,
    KIND_READ,
    KIND_ADD
  } kind_e;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_CLEAR,
    DP_CAPTURE,
    DP_EARLY,
    DP_SRCH_RD,
    DP_SRCH_CMP,
    DP_CHECK,
    DP_STORE_RD,
    DP_READ_RES,
    DP_PREP,
    DP_MUL_Y,
    DP_MUL_MAG,
    DP_DIV_START,
    DP_NEWMEAN,
    DP_MUL_DEV,
    DP_MUL_PLO,
    DP_MUL_PHI,
    DP_TERM,
    DP_WRITE
  } dp_op_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_CHECK,
    S_STORE_RD,
    S_READ_RES,
    S_UPDATE,
    S_MUL_MAG,
    S_DIV_START,
    S_DIV_WAIT,
    S_MUL_DEV,
    S_MUL_PLO,
    S_MUL_PHI,
    S_TERM,
    S_WRITE,
    S_FINISH
  } state_e;

  typedef struct packed {
    dp_op_e op;
    logic   out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    kind_e      kind;
    logic       srch_done;
    logic       type_ok;
    logic [2:0] ptype;
    logic       div_busy;
    logic       clr_last;
  } dp_stat_t;

endpackage

// ----- hw/rtl/brs_div.sv -----
// Restoring divider, one quotient bit per cycle, for the running mean step.
// Depends on nothing outside this file.
module brs_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [47:0] divisor_i,
  output logic        busy_o,
  output logic [63:0] quotient_o
);

  localparam int CNT_W = $clog2(64 + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [63:0]      quo_q;
  logic [47:0]      rem_q;
  logic [47:0]      div_q;
  logic [48:0]      trial;
  logic [48:0]      diff;
  logic             take;

  assign trial = {rem_q, quo_q[63]};
  assign diff  = trial - {1'b0, div_q};
  assign take  = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(64);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so 48 bits hold it.
      rem_q <= take ? diff[47:0] : trial[47:0];
      quo_q <= {quo_q[62:0], take};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ----- hw/rtl/brs_datapath.sv -----
// Datapath: configuration registers, edge and statistics memories, search,
// shared multiplier, divider and result registers. Uses brs_pkg and brs_div.
module brs_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  brs_pkg::in_item_t    in_data_i,
  input  brs_pkg::ctrl_cmd_t   cmd_i,
  output brs_pkg::dp_stat_t    stat_o,
  output brs_pkg::out_item_t   out_data_o
);

  localparam int BIN_W   = brs_pkg::BIN_W;
  localparam int NUM_W   = brs_pkg::NUM_W;
  localparam int SADDR_W = brs_pkg::SADDR_W;

  function automatic logic [47:0] add_sat48(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[48] ? {48{1'b1}} : s[47:0];
  endfunction

  function automatic logic signed [63:0] add_sat64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  // Configuration.
  logic signed [31:0] xmin_q, xmax_q;
  logic [8:0]         bcount_q;
  logic [11:0]        ptypes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xmin_q   <= 32'sd0;
      xmax_q   <= 32'sd65536;
      bcount_q <= 9'd256;
      ptypes_q <= 12'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        brs_pkg::CFG_X_MINIMUM:      xmin_q   <= cfg_data_i;
        brs_pkg::CFG_X_MAXIMUM:      xmax_q   <= cfg_data_i;
        brs_pkg::CFG_BIN_COUNT:      bcount_q <= cfg_data_i[8:0];
        brs_pkg::CFG_PROPERTY_TYPES: ptypes_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  brs_pkg::in_item_t  item_q;
  brs_pkg::out_item_t res_q, out_q;

  logic signed [31:0] edge_mem [brs_pkg::NUM_BINS];
  logic signed [31:0] edge_rd_q;
  logic [BIN_W-1:0]   lo_q, hi_q, mid_q;
  logic               mid_last_q;

  logic [47:0]        cnt_mem  [brs_pkg::STORE_DEPTH];
  logic signed [63:0] mean_mem [brs_pkg::STORE_DEPTH];
  logic signed [63:0] dev_mem  [brs_pkg::STORE_DEPTH];
  logic [47:0]        rd_cnt_q;
  logic signed [63:0] rd_mean_q, rd_dev_q;
  logic [SADDR_W-1:0] k_q, clr_q;

  logic [47:0]        cnt_q;
  logic signed [31:0] prev_q;
  logic               neg_q;
  logic [31:0]        mag_q;
  logic signed [63:0] nm_q;
  logic [47:0]        p_q;
  logic [55:0]        plo_q;
  logic [63:0]        term_q;
  logic signed [65:0] prod_q;

  logic               div_busy;
  logic [63:0]        quotient;

  // Decode of the captured item.
  logic [NUM_W-1:0]   n_use;
  logic [BIN_W-1:0]   last_idx, mid, bin_sel;
  logic [BIN_W:0]     mid_sum;
  logic [2:0]         ptype;
  logic               exists, type_ok, bad_idx, out_range, is_bin_op;
  brs_pkg::kind_e     kind;
  brs_pkg::out_item_t early_res;
  logic [SADDR_W-1:0] k;
  logic signed [31:0] edge_val;

  always_comb begin
    if (bcount_q == 9'd0) begin
      n_use = NUM_W'(1);
    end else if (int'(bcount_q) > brs_pkg::NUM_BINS) begin
      n_use = NUM_W'(brs_pkg::NUM_BINS);
    end else begin
      n_use = NUM_W'(bcount_q);
    end
    last_idx = BIN_W'(n_use - NUM_W'(1));
    mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
    mid      = mid_sum[BIN_W:1];

    if (int'(item_q.property_req) < brs_pkg::NUM_PROPS) begin
      ptype = ptypes_q[3*int'(item_q.property_req) +: 3];
    end else begin
      ptype = brs_pkg::PT_NONE;
    end
    exists  = (ptype >= brs_pkg::PT_COUNT) && (ptype <= brs_pkg::PT_VALUE);
    type_ok = exists && ((item_q.operation == brs_pkg::OP_INC_COUNT) ==
                         (ptype == brs_pkg::PT_COUNT));
    bad_idx   = int'(item_q.bin_index) >= brs_pkg::NUM_BINS;
    out_range = (item_q.x_value < xmin_q) || (item_q.x_value > xmax_q);
    is_bin_op = (item_q.operation == brs_pkg::OP_LOAD_EDGE) ||
                (item_q.operation == brs_pkg::OP_READ_BIN);

    early_res = '0;
    if (is_bin_op) begin
      if (bad_idx) begin
        early_res.status = brs_pkg::ST_OUT_OF_RANGE;
        kind = brs_pkg::KIND_EARLY;
      end else if (item_q.operation == brs_pkg::OP_LOAD_EDGE) begin
        early_res.status = brs_pkg::ST_OK;
        early_res.bin    = item_q.bin_index;
        kind = brs_pkg::KIND_EARLY;
      end else if (!exists) begin
        early_res.status = brs_pkg::ST_NO_PROPERTY;
        early_res.bin    = item_q.bin_index;
        kind = brs_pkg::KIND_EARLY;
      end else begin
        kind = brs_pkg::KIND_READ;
      end
    end else if (out_range) begin
      early_res.status = brs_pkg::ST_OUT_OF_RANGE;
      kind = brs_pkg::KIND_EARLY;
    end else if (item_q.increment == 32'd0) begin
      early_res.status = brs_pkg::ST_ZERO_WEIGHT;
      kind = brs_pkg::KIND_EARLY;
    end else begin
      kind = brs_pkg::KIND_ADD;
    end

    bin_sel  = (item_q.operation == brs_pkg::OP_READ_BIN) ? BIN_W'(item_q.bin_index) : lo_q;
    k        = SADDR_W'(item_q.property_req) * SADDR_W'(brs_pkg::NUM_BINS) + SADDR_W'(bin_sel);
    // The last bin in use always ends at x_maximum.
    edge_val = mid_last_q ? xmax_q : edge_rd_q;
  end

  // Capture and binary search over the bin edges: read an edge, then compare.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      brs_pkg::DP_CAPTURE: item_q <= in_data_i;
      brs_pkg::DP_EARLY: begin
        lo_q <= '0;
        hi_q <= last_idx;
      end
      brs_pkg::DP_SRCH_RD: begin
        mid_q      <= mid;
        mid_last_q <= (mid == last_idx);
      end
      brs_pkg::DP_SRCH_CMP: begin
        if (edge_val < item_q.x_value) begin
          lo_q <= mid_q + BIN_W'(1);
        end else begin
          hi_q <= mid_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == brs_pkg::DP_EARLY && item_q.operation == brs_pkg::OP_LOAD_EDGE &&
        !bad_idx) begin
      edge_mem[BIN_W'(item_q.bin_index)] <= item_q.x_value;
    end
    if (cmd_i.op == brs_pkg::DP_SRCH_RD) begin
      edge_rd_q <= edge_mem[mid];
    end
  end

  // Shared multiplier with a registered product.
  logic signed [32:0] mul_a, mul_b;
  logic signed [63:0] d1;
  logic [31:0]        a_abs;

  always_comb begin
    d1    = $signed({{32{item_q.y_value[31]}}, item_q.y_value}) - nm_q;
    a_abs = d1[63] ? 32'(-d1) : d1[31:0];
    case (cmd_i.op)
      brs_pkg::DP_MUL_Y: begin
        mul_a = {item_q.y_value[31], item_q.y_value};
        mul_b = {1'b0, item_q.increment};
      end
      brs_pkg::DP_MUL_MAG: begin
        mul_a = {1'b0, mag_q};
        mul_b = {1'b0, item_q.increment};
      end
      brs_pkg::DP_MUL_DEV: begin
        mul_a = {1'b0, a_abs};
        mul_b = {1'b0, mag_q};
      end
      brs_pkg::DP_MUL_PLO: begin
        mul_a = {9'd0, prod_q[39:16]};
        mul_b = {1'b0, item_q.increment};
      end
      brs_pkg::DP_MUL_PHI: begin
        mul_a = {9'd0, p_q[47:24]};
        mul_b = {1'b0, item_q.increment};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  brs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.op == brs_pkg::DP_DIV_START),
    .dividend_i (prod_q[63:0]),
    .divisor_i  (cnt_q),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // Mean preparation and deviation term.
  logic signed [31:0] prev_d;
  logic signed [32:0] dlt;
  logic signed [63:0] prev_ext, nm_d;
  logic [79:0]        full;

  always_comb begin
    if (rd_mean_q > 64'sd2147483647) begin
      prev_d = 32'sh7FFFFFFF;
    end else if (rd_mean_q < -64'sd2147483648) begin
      prev_d = 32'sh80000000;
    end else begin
      prev_d = rd_mean_q[31:0];
    end
    dlt      = $signed({item_q.y_value[31], item_q.y_value}) - $signed({prev_d[31], prev_d});
    prev_ext = $signed({{32{prev_q[31]}}, prev_q});
    nm_d     = neg_q ? prev_ext - $signed({32'd0, quotient[31:0]})
                     : prev_ext + $signed({32'd0, quotient[31:0]});
    full     = {prod_q[55:0], 24'd0} + {24'd0, plo_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == brs_pkg::DP_MUL_Y || cmd_i.op == brs_pkg::DP_MUL_MAG ||
        cmd_i.op == brs_pkg::DP_MUL_DEV || cmd_i.op == brs_pkg::DP_MUL_PLO ||
        cmd_i.op == brs_pkg::DP_MUL_PHI) begin
      prod_q <= mul_a * mul_b;
    end
    case (cmd_i.op)
      brs_pkg::DP_PREP: begin
        cnt_q  <= add_sat48(rd_cnt_q, item_q.increment);
        prev_q <= prev_d;
        neg_q  <= dlt[32];
        mag_q  <= dlt[32] ? 32'(-dlt) : dlt[31:0];
      end
      brs_pkg::DP_NEWMEAN: nm_q  <= nm_d;
      brs_pkg::DP_MUL_PLO: p_q   <= prod_q[63:16];
      brs_pkg::DP_MUL_PHI: plo_q <= prod_q[55:0];
      brs_pkg::DP_TERM: begin
        term_q <= (full > {16'd0, 1'b0, {63{1'b1}}}) ? {1'b0, {63{1'b1}}} : full[63:0];
      end
      default: ;
    endcase
  end

  // Store update values.
  logic [47:0]        upd_cnt;
  logic signed [63:0] upd_mean, upd_dev;

  always_comb begin
    upd_cnt  = rd_cnt_q;
    upd_mean = rd_mean_q;
    upd_dev  = rd_dev_q;
    case (ptype)
      brs_pkg::PT_COUNT: upd_cnt = add_sat48(rd_cnt_q, item_q.increment);
      brs_pkg::PT_SUM:   upd_mean = add_sat64(rd_mean_q, $signed(prod_q[63:0]));
      brs_pkg::PT_VALUE: upd_mean = $signed({{32{item_q.y_value[31]}}, item_q.y_value});
      brs_pkg::PT_MEAN: begin
        upd_cnt  = cnt_q;
        upd_mean = nm_q;
      end
      brs_pkg::PT_MEAN_DEV: begin
        upd_cnt  = cnt_q;
        upd_mean = nm_q;
        upd_dev  = add_sat64(rd_dev_q, $signed(term_q));
      end
      default: ;
    endcase
  end

  // Statistics memories; the clearing pass after reset writes zeros.
  logic               st_we;
  logic [SADDR_W-1:0] st_addr;

  assign st_we   = (cmd_i.op == brs_pkg::DP_CLEAR) || (cmd_i.op == brs_pkg::DP_WRITE);
  assign st_addr = (cmd_i.op == brs_pkg::DP_CLEAR) ? clr_q : k_q;

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      cnt_mem[st_addr]  <= (cmd_i.op == brs_pkg::DP_CLEAR) ? 48'd0 : upd_cnt;
      mean_mem[st_addr] <= (cmd_i.op == brs_pkg::DP_CLEAR) ? 64'sd0 : upd_mean;
      dev_mem[st_addr]  <= (cmd_i.op == brs_pkg::DP_CLEAR) ? 64'sd0 : upd_dev;
    end
    if (cmd_i.op == brs_pkg::DP_STORE_RD) begin
      rd_cnt_q  <= cnt_mem[k];
      rd_mean_q <= mean_mem[k];
      rd_dev_q  <= dev_mem[k];
      k_q       <= k;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.op == brs_pkg::DP_CLEAR) begin
      clr_q <= clr_q + SADDR_W'(1);
    end
  end

  // Working result and output register.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      brs_pkg::DP_EARLY: res_q <= early_res;
      brs_pkg::DP_CHECK: begin
        res_q <= '{status: (exists ? brs_pkg::ST_WRONG_TYPE : brs_pkg::ST_NO_PROPERTY),
                   bin: 8'(lo_q), default: '0};
      end
      brs_pkg::DP_READ_RES: begin
        res_q <= '{status: brs_pkg::ST_OK, bin: item_q.bin_index, total_count: rd_cnt_q,
                   mean_or_sum: rd_mean_q, squared_deviation: rd_dev_q};
      end
      brs_pkg::DP_WRITE: begin
        res_q <= '{status: brs_pkg::ST_OK, bin: 8'(lo_q), total_count: upd_cnt,
                   mean_or_sum: upd_mean, squared_deviation: upd_dev};
      end
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign stat_o.kind      = kind;
  assign stat_o.srch_done = (lo_q >= hi_q);
  assign stat_o.type_ok   = type_ok;
  assign stat_o.ptype     = ptype;
  assign stat_o.div_busy  = div_busy;
  assign stat_o.clr_last  = &clr_q;
  assign out_data_o       = out_q;

endmodule

// ----- hw/rtl/brs_ctrl.sv -----
// Controller state machine: sequences the datapath for one item at a time
// and owns the input ready and output valid. Uses brs_pkg.
module brs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  brs_pkg::dp_stat_t  stat_i,
  output brs_pkg::ctrl_cmd_t cmd_o
);

  brs_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= brs_pkg::S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o.op       = brs_pkg::DP_NOP;
    cmd_o.out_load = 1'b0;
    in_ready_o     = 1'b0;
    case (state_q)
      brs_pkg::S_CLEAR: begin
        cmd_o.op = brs_pkg::DP_CLEAR;
        if (stat_i.clr_last) state_d = brs_pkg::S_IDLE;
      end
      brs_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = brs_pkg::DP_CAPTURE;
          state_d  = brs_pkg::S_DECODE;
        end
      end
      brs_pkg::S_DECODE: begin
        cmd_o.op = brs_pkg::DP_EARLY;
        case (stat_i.kind)
          brs_pkg::KIND_READ: state_d = brs_pkg::S_STORE_RD;
          brs_pkg::KIND_ADD:  state_d = brs_pkg::S_SRCH_RD;
          default:            state_d = brs_pkg::S_FINISH;
        endcase
      end
      brs_pkg::S_SRCH_RD: begin
        if (stat_i.srch_done) begin
          state_d = brs_pkg::S_CHECK;
        end else begin
          cmd_o.op = brs_pkg::DP_SRCH_RD;
          state_d  = brs_pkg::S_SRCH_CMP;
        end
      end
      brs_pkg::S_SRCH_CMP: begin
        cmd_o.op = brs_pkg::DP_SRCH_CMP;
        state_d  = brs_pkg::S_SRCH_RD;
      end
      brs_pkg::S_CHECK: begin
        if (stat_i.type_ok) begin
          cmd_o.op = brs_pkg::DP_STORE_RD;
          state_d  = brs_pkg::S_UPDATE;
        end else begin
          cmd_o.op = brs_pkg::DP_CHECK;
          state_d  = brs_pkg::S_FINISH;
        end
      end
      brs_pkg::S_STORE_RD: begin
        cmd_o.op = brs_pkg::DP_STORE_RD;
        state_d  = brs_pkg::S_READ_RES;
      end
      brs_pkg::S_READ_RES: begin
        cmd_o.op = brs_pkg::DP_READ_RES;
        state_d  = brs_pkg::S_FINISH;
      end
      brs_pkg::S_UPDATE: begin
        case (stat_i.ptype)
          brs_pkg::PT_SUM: begin
            cmd_o.op = brs_pkg::DP_MUL_Y;
            state_d  = brs_pkg::S_WRITE;
          end
          brs_pkg::PT_MEAN, brs_pkg::PT_MEAN_DEV: begin
            cmd_o.op = brs_pkg::DP_PREP;
            state_d  = brs_pkg::S_MUL_MAG;
          end
          default: begin
            cmd_o.op = brs_pkg::DP_WRITE;
            state_d  = brs_pkg::S_FINISH;
          end
        endcase
      end
      brs_pkg::S_MUL_MAG: begin
        cmd_o.op = brs_pkg::DP_MUL_MAG;
        state_d  = brs_pkg::S_DIV_START;
      end
      brs_pkg::S_DIV_START: begin
        cmd_o.op = brs_pkg::DP_DIV_START;
        state_d  = brs_pkg::S_DIV_WAIT;
      end
      brs_pkg::S_DIV_WAIT: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = brs_pkg::DP_NEWMEAN;
          state_d  = (stat_i.ptype == brs_pkg::PT_MEAN_DEV) ? brs_pkg::S_MUL_DEV
                                                            : brs_pkg::S_WRITE;
        end
      end
      brs_pkg::S_MUL_DEV: begin
        cmd_o.op = brs_pkg::DP_MUL_DEV;
        state_d  = brs_pkg::S_MUL_PLO;
      end
      brs_pkg::S_MUL_PLO: begin
        cmd_o.op = brs_pkg::DP_MUL_PLO;
        state_d  = brs_pkg::S_MUL_PHI;
      end
      brs_pkg::S_MUL_PHI: begin
        cmd_o.op = brs_pkg::DP_MUL_PHI;
        state_d  = brs_pkg::S_TERM;
      end
      brs_pkg::S_TERM: begin
        cmd_o.op = brs_pkg::DP_TERM;
        state_d  = brs_pkg::S_WRITE;
      end
      brs_pkg::S_WRITE: begin
        cmd_o.op = brs_pkg::DP_WRITE;
        state_d  = brs_pkg::S_FINISH;
      end
      brs_pkg::S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = brs_pkg::S_IDLE;
        end
      end
      default: state_d = brs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hw/rtl/binned_running_statistics.sv -----
// Top level of the binned running statistics engine.
// Depends on brs_pkg, brs_ctrl and brs_datapath.
//
// Usage: items arrive on the in_* valid/ready channel, one transfer per item,
// and every item gives exactly one result transfer on the out_* channel.
// An item loads a bin edge, reads the stores of one bin, or adds a weighted
// sample to a property (count, sum, running mean, mean plus squared
// deviation, or last value). Configuration registers are written through
// cfg_we_i / cfg_index_i / cfg_data_i; the user must write them only while
// the block is idle, which the block itself does not enforce. A load, a
// rejected sample or a failed read ends after decode; a read first reads
// the stores of its bin. A sample runs the bin search, one edge read and
// one compare per halving step, then its update: a direct write for a
// count or value, a multiply for a sum, a multiply and the 64-step
// restoring divider for a running mean, and further multiplies for mean
// plus deviation; a property or type error ends after the search. One item
// is in work at a time; in_ready_o rises in the same cycle as out_valid_o,
// once the result enters the output register.
// After reset the block sweeps the 1024-entry count, mean and deviation
// memories to zero, one entry per cycle, with in_ready_o low until done.
// When the receiver stalls, the result waits in the output register; the
// block takes one more item and then holds it until that register is free.
module binned_running_statistics (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  brs_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output brs_pkg::out_item_t out_data_o
);

  // Command and status between the sequencer and the datapath.
  brs_pkg::ctrl_cmd_t cmd;
  brs_pkg::dp_stat_t  stat;

  brs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  brs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hw/rtl/brs_checker.sv -----
// Port-level checks of the binned running statistics engine, bound to the top.
// Depends on brs_pkg and binned_running_statistics.
module brs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input brs_pkg::out_item_t out_data_o
);

  logic       in_xfer, out_xfer;
  logic [1:0] pend_q;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else begin
      pend_q <= pend_q + {1'b0, in_xfer} - {1'b0, out_xfer};
    end
  end

  // One item at a time: ready drops after every input transfer.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // No result without an item, and at most one item beyond the one waiting.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> pend_q != 2'd0)
    else $error("result without an item");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> pend_q != 2'd2)
    else $error("too many items in flight");

  // Any result other than a success carries zero statistics.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != brs_pkg::ST_OK |->
      out_data_o.total_count == 48'd0 && out_data_o.mean_or_sum == 64'sd0 &&
      out_data_o.squared_deviation == 64'sd0)
    else $error("failed result carries statistics");

endmodule

bind binned_running_statistics brs_checker u_brs_checker (.*);
